>>> rtl/egcd_pkg.sv
package egcd_pkg;

  localparam int FIELD_W   = 64;
  localparam int WIDTH_DEF = 64;

  typedef struct packed {
    logic load;      // take a new request into the working registers
    logic init;      // set up the divider for one quotient step
    logic step;      // one restoring-division / multiply-accumulate iteration
    logic update;    // shift the Euclid registers after a quotient step
    logic out_load;  // copy the result into the output register
  } egcd_cmd_t;

  typedef struct packed {
    logic den_zero;
  } egcd_status_t;

endpackage

>>> rtl/egcd_ctrl.sv
module egcd_ctrl #(
  parameter int WIDTH = egcd_pkg::WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  egcd_pkg::egcd_status_t status,
  output egcd_pkg::egcd_cmd_t    cmd
);
  import egcd_pkg::*;

  localparam int CNT_W = $clog2(WIDTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TEST = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovalid_r, ovalid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    ovalid_nxt = ovalid_r;
    cmd        = '0;
    if (ovalid_r && out_tready) begin
      ovalid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_TEST;
        end
      end
      S_TEST: begin
        if (status.den_zero) begin
          state_nxt = S_DONE;
        end else begin
          cmd.init  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(WIDTH - 1)) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = S_TEST;
      end
      S_DONE: begin
        if (!ovalid_r || out_tready) begin
          cmd.out_load = 1'b1;
          ovalid_nxt   = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

endmodule

>>> rtl/egcd_dp.sv
module egcd_dp #(
  parameter int WIDTH = egcd_pkg::WIDTH_DEF
) (
  input  logic                          clk,
  input  logic [egcd_pkg::FIELD_W-1:0]  a_value,
  input  logic [egcd_pkg::FIELD_W-1:0]  b_value,
  input  egcd_pkg::egcd_cmd_t           cmd,
  output egcd_pkg::egcd_status_t        status,
  output logic [egcd_pkg::FIELD_W-1:0]  coefficient_x,
  output logic [egcd_pkg::FIELD_W-1:0]  divisor
);
  import egcd_pkg::*;

  logic [WIDTH-1:0] num_r, den_r, xp_r, xc_r;
  logic [WIDTH-1:0] dvd_r, dsr_r, rem_r, acc_r;
  logic             qneg_r, rneg_r;
  logic [FIELD_W-1:0] ox_r, og_r;

  logic [WIDTH-1:0] num_mag, den_mag;
  logic [WIDTH:0]   trial, diff;
  logic             qbit;
  logic [WIDTH-1:0] rem_nxt, acc_nxt, r_signed, x_next;

  assign num_mag = num_r[WIDTH-1] ? (WIDTH'(0) - num_r) : num_r;
  assign den_mag = den_r[WIDTH-1] ? (WIDTH'(0) - den_r) : den_r;

  // restoring division, quotient bits MSB first; the same bits feed a
  // Horner-style product |q| * x_cur (mod 2^WIDTH)
  assign trial   = {rem_r, dvd_r[WIDTH-1]};
  assign diff    = trial - {1'b0, dsr_r};
  assign qbit    = ~diff[WIDTH];
  assign rem_nxt = qbit ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
  assign acc_nxt = {acc_r[WIDTH-2:0], 1'b0} + (qbit ? xc_r : WIDTH'(0));

  assign r_signed = rneg_r ? (WIDTH'(0) - rem_r) : rem_r;
  assign x_next   = qneg_r ? (xp_r + acc_r) : (xp_r - acc_r);

  assign status.den_zero = (den_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num_r <= a_value[WIDTH-1:0];
      den_r <= b_value[WIDTH-1:0];
      xp_r  <= WIDTH'(1);
      xc_r  <= '0;
    end else if (cmd.update) begin
      num_r <= den_r;
      den_r <= r_signed;
      xp_r  <= xc_r;
      xc_r  <= x_next;
    end
    if (cmd.init) begin
      dvd_r  <= num_mag;
      dsr_r  <= den_mag;
      rem_r  <= '0;
      acc_r  <= '0;
      qneg_r <= num_r[WIDTH-1] ^ den_r[WIDTH-1];
      rneg_r <= num_r[WIDTH-1];
    end else if (cmd.step) begin
      dvd_r <= {dvd_r[WIDTH-2:0], 1'b0};
      rem_r <= rem_nxt;
      acc_r <= acc_nxt;
    end
    if (cmd.out_load) begin
      ox_r <= FIELD_W'($signed(xp_r));
      og_r <= FIELD_W'($signed(num_r));
    end
  end

  assign coefficient_x = ox_r;
  assign divisor       = og_r;

endmodule

>>> rtl/extended_gcd_bezout_core.sv
// Extended Euclid core: gcd of two signed operands plus the Bezout
// coefficient x of the first operand (a*x == gcd mod b), truncating division.
//
// Input channel in_*: one request per accepted beat, in_tdata = {b, a}.
// Output channel out_*: one result per request, out_tdata = {gcd, x}.
// Operands use their low WIDTH bits as signed values; results are WIDTH-bit
// values sign-extended to 64 bits.
//
// One request is worked on at a time. Each quotient step runs the shared
// radix-2 divider, which also forms q*x one bit per cycle.
// A finished result sits in the output register; the next request is taken
// as soon as that register is loaded. If the receiver stalls and the next
// result is done, the core holds it until out_tready frees the register.
// Reset (rst_n low, synchronous) drops any request in flight and the result.
module extended_gcd_bezout_core #(
  parameter int WIDTH = egcd_pkg::WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [2*egcd_pkg::FIELD_W-1:0]  in_tdata,   // a_value, b_value
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [2*egcd_pkg::FIELD_W-1:0]  out_tdata   // coefficient_x, divisor
);
  import egcd_pkg::*;

  egcd_cmd_t          cmd;
  egcd_status_t       status;
  logic [FIELD_W-1:0] coef_x, gcd_v;

  egcd_ctrl #(.WIDTH(WIDTH)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  egcd_dp #(.WIDTH(WIDTH)) u_dp (
    .clk           (clk),
    .a_value       (in_tdata[FIELD_W-1:0]),
    .b_value       (in_tdata[2*FIELD_W-1:FIELD_W]),
    .cmd           (cmd),
    .status        (status),
    .coefficient_x (coef_x),
    .divisor       (gcd_v)
  );

  assign out_tdata = {gcd_v, coef_x};

endmodule

>>> tb/tb_extended_gcd_bezout_core.sv
module tb_extended_gcd_bezout_core;

  localparam int WIDTH        = egcd_pkg::WIDTH_DEF;
  localparam int FW           = egcd_pkg::FIELD_W;
  localparam int CYCLE_LIMIT  = 6000000;
  localparam int DRAIN_CYCLES = 6500;
  localparam int HOLD_AT      = 85;
  localparam int HOLD_CYCLES  = 20000;
  localparam int PHASE_ITEMS  = 26;

  typedef logic [FW-1:0] word_t;

  typedef struct packed {
    word_t divisor;
    word_t coefficient_x;
  } bezout_t;

  localparam word_t MIN_VAL = {1'b1, {(FW-1){1'b0}}};
  localparam word_t MAX_VAL = {1'b0, {(FW-1){1'b1}}};

  class bezout_scoreboard;
    bezout_t bezout_queue[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function word_t wrap_width(word_t v);
      word_t mask = {FW{1'b1}} >> (FW - WIDTH);
      word_t sgn = word_t'(1) << (WIDTH - 1);
      return ((v & mask) ^ sgn) - sgn;
    endfunction

    // truncating signed Euclid, coefficient of the first operand only
    function bezout_t predict_bezout(word_t a, word_t b);
      word_t num = wrap_width(a);
      word_t den = wrap_width(b);
      word_t x_prev = 1;
      word_t x_cur = 0;
      word_t mn, md, q, r, x_next;
      bezout_t res;
      while (den != 0) begin
        mn = num[FW-1] ? -num : num;
        md = den[FW-1] ? -den : den;
        q = mn / md;
        r = mn % md;
        if (num[FW-1] != den[FW-1]) q = -q;
        if (num[FW-1]) r = -r;
        q = wrap_width(q);
        r = wrap_width(r);
        x_next = wrap_width(x_prev - q * x_cur);
        x_prev = x_cur;
        x_cur = x_next;
        num = den;
        den = r;
      end
      res.coefficient_x = x_prev;
      res.divisor = num;
      return res;
    endfunction

    function void note_request(word_t a, word_t b);
      bezout_queue.push_back(predict_bezout(a, b));
    endfunction

    function void check_result(word_t coef, word_t g);
      bezout_t want;
      if (bezout_queue.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual x=%h gcd=%h", $time, coef, g);
        errors++;
        return;
      end
      want = bezout_queue.pop_front();
      if (coef !== want.coefficient_x) begin
        $display("%0t: coefficient_x mismatch: expected %h actual %h",
                 $time, want.coefficient_x, coef);
        errors++;
      end
      if (g !== want.divisor) begin
        $display("%0t: divisor mismatch: expected %h actual %h", $time, want.divisor, g);
        errors++;
      end
    endfunction

    function int outstanding();
      return bezout_queue.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [2*FW-1:0] in_tdata = '0;   // a_value, b_value
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [2*FW-1:0] out_tdata;       // coefficient_x, divisor

  bezout_scoreboard sb;
  int send_idle_pct = 15;
  int recv_idle_pct = 74;
  int accepted_count = 0;
  int hold_left = 0;
  bit hold_done = 0;
  int cycle_count = 0;

  extended_gcd_bezout_core #(.WIDTH(WIDTH)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver; one long hold-off once the input side has been busy a while
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else if (!hold_done && accepted_count == HOLD_AT) begin
      hold_done = 1;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        sb.note_request(in_tdata[FW-1:0], in_tdata[2*FW-1:FW]);
        accepted_count <= accepted_count + 1;
      end
      if (out_tvalid && out_tready)
        sb.check_result(out_tdata[FW-1:0], out_tdata[2*FW-1:FW]);
    end
  end

  function automatic word_t fib_value(int n);
    word_t f0 = 0;
    word_t f1 = 1;
    word_t t;
    repeat (n) begin
      t = f0 + f1;
      f0 = f1;
      f1 = t;
    end
    return f0;
  endfunction

  task automatic send_request(input word_t a, input word_t b);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata <= {b, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      if ($urandom_range(9) == 0) gap = $urandom_range(4000, 50);
      else gap = $urandom_range(8, 1);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random();
    word_t a, b, g;
    word_t corner[5];
    int n;
    corner = '{word_t'(0), MIN_VAL, MAX_VAL, word_t'(1), {FW{1'b1}}};
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(9))
      0, 1, 2: ;
      3, 4, 5: begin
        a = $signed(a) >>> $urandom_range(62);
        b = $signed(b) >>> $urandom_range(62);
      end
      6: begin
        g = word_t'($urandom_range(65535, 1));
        a = g * word_t'($signed(a) >>> 40);
        b = g * word_t'($signed(b) >>> 40);
      end
      7: begin
        if ($urandom_range(1)) b = corner[$urandom_range(4)];
        else a = corner[$urandom_range(4)];
      end
      8: begin
        n = $urandom_range(92, 60);
        a = fib_value(n);
        b = fib_value(n - 1);
        if ($urandom_range(1)) a = -a;
        if ($urandom_range(1)) b = -b;
      end
      default: begin
        b = $urandom_range(1) ? a : -a;
      end
    endcase
    send_request(a, b);
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(0, 0);
    send_request(123456789, 0);
    send_request(MIN_VAL, 0);
    send_request(0, 987654321);
    send_request(0, MIN_VAL);
    send_request(MIN_VAL, {FW{1'b1}});
    send_request(MIN_VAL, 1);
    send_request(MIN_VAL, MIN_VAL);
    send_request(MAX_VAL, MAX_VAL);
    send_request(MAX_VAL, MIN_VAL);
    send_request(MIN_VAL, MAX_VAL);
    send_request({FW{1'b1}}, {FW{1'b1}});
    send_request(1, {FW{1'b1}});
    send_request({FW{1'b1}}, MIN_VAL);
    send_request(240, 46);
    send_request(-64'sd240, 46);
    send_request(240, -64'sd46);
    send_request(-64'sd240, -64'sd46);
    send_request(fib_value(92), fib_value(91));
    send_request(-fib_value(92), fib_value(91));
    send_request(MIN_VAL, 3);
    send_request(MAX_VAL, -64'sd2);
    send_request({(FW/2){2'b10}}, {(FW/2){2'b01}});

    repeat (PHASE_ITEMS) send_random();
    send_idle_pct = 74;
    recv_idle_pct <= 15;
    repeat (PHASE_ITEMS) send_random();
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    repeat (PHASE_ITEMS) send_random();
    in_tvalid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> extended_gcd_bezout_core.f
rtl/egcd_pkg.sv
rtl/egcd_ctrl.sv
rtl/egcd_dp.sv
rtl/extended_gcd_bezout_core.sv
tb/tb_extended_gcd_bezout_core.sv
